// ===== rtl/aes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg
// shared constants, types and byte functions for the aes-128 round pipeline
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned BLOCK_W    = 128;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [7:0]         byte_t;

    typedef struct packed {
        logic   valid;
        block_t state;
        block_t round_key;
        byte_t  rcon;
    } stage_t;

    localparam logic [2:0] REG_KEY_HIGH = 3'h0;
    localparam logic [2:0] REG_KEY_LOW  = 3'h1;

    localparam byte_t REDUCE_POLY = 8'h1b;
    localparam byte_t RCON_FIRST  = 8'h01;

    localparam byte_t SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic byte_t gf_dbl(input byte_t a);
        gf_dbl = {a[6:0], 1'b0} ^ (a[7] ? REDUCE_POLY : 8'h00);
    endfunction

    // byte n of the block sits at bits [127-8n -: 8]
    function automatic byte_t get_byte(input block_t b, input int unsigned n);
        get_byte = b[BLOCK_W-1-8*n -: 8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/aes_round_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_round_cell
// one registered aes round with its on-the-fly key expansion step
// ----------------------------------------------------------------------------
module aes_round_cell #(
    parameter bit LAST_ROUND = 1'b0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire aes_pkg::stage_t prev,
    output aes_pkg::stage_t     curr
);

    aes_pkg::block_t key_next;
    aes_pkg::block_t state_next;
    aes_pkg::block_t ss;
    aes_pkg::block_t mc;
    aes_pkg::byte_t  t [4];
    aes_pkg::byte_t  kb [16];
    aes_pkg::byte_t  a0, a1, a2, a3;

    logic            valid_reg;
    aes_pkg::block_t state_reg;
    aes_pkg::block_t key_reg;
    aes_pkg::byte_t  rcon_reg;

    always_comb
    begin
        t[0] = aes_pkg::SBOX[aes_pkg::get_byte(prev.round_key, 13)] ^ prev.rcon;
        t[1] = aes_pkg::SBOX[aes_pkg::get_byte(prev.round_key, 14)];
        t[2] = aes_pkg::SBOX[aes_pkg::get_byte(prev.round_key, 15)];
        t[3] = aes_pkg::SBOX[aes_pkg::get_byte(prev.round_key, 12)];
        for (int r = 0; r < 4; r++)
        begin
            kb[r] = aes_pkg::get_byte(prev.round_key, r) ^ t[r];
        end
        for (int c = 1; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                kb[4*c+r] = aes_pkg::get_byte(prev.round_key, 4*c+r) ^ kb[4*(c-1)+r];
            end
        end
        for (int n = 0; n < 16; n++)
        begin
            key_next[127-8*n -: 8] = kb[n];
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                ss[127-8*(4*c+r) -: 8] =
                    aes_pkg::SBOX[aes_pkg::get_byte(prev.state, 4*((c+r)%4)+r)];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = aes_pkg::get_byte(ss, 4*c);
            a1 = aes_pkg::get_byte(ss, 4*c+1);
            a2 = aes_pkg::get_byte(ss, 4*c+2);
            a3 = aes_pkg::get_byte(ss, 4*c+3);
            mc[127-8*(4*c)   -: 8] = aes_pkg::gf_dbl(a0) ^ aes_pkg::gf_dbl(a1) ^ a1 ^ a2 ^ a3;
            mc[127-8*(4*c+1) -: 8] = a0 ^ aes_pkg::gf_dbl(a1) ^ aes_pkg::gf_dbl(a2) ^ a2 ^ a3;
            mc[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ aes_pkg::gf_dbl(a2) ^ aes_pkg::gf_dbl(a3) ^ a3;
            mc[127-8*(4*c+3) -: 8] = aes_pkg::gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::gf_dbl(a3);
        end
        state_next = (LAST_ROUND ? ss : mc) ^ key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
            rcon_reg  <= aes_pkg::gf_dbl(prev.rcon);
        end
    end

    assign curr = '{valid: valid_reg, state: state_reg, round_key: key_reg, rcon: rcon_reg};

endmodule

`default_nettype wire

// ===== rtl/aes128_block_encryptor_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes128_block_encryptor_core
// aes-128 encryptor as a row of ten round cells behind an input key-add stage
// ----------------------------------------------------------------------------
// eleven register stages, the input key-add stage and the ten round cells, lie between input transfer and result valid
// throughput: one block per cycle while the output is not stalled, set by one round cell per pipeline stage
// the whole row stalls together when the output is held and the last stage is full
// reset clears all valid flags and both key registers to zero
module aes128_block_encryptor_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] plain_high,
    input  wire logic [63:0] plain_low,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [63:0] cipher_high,
    output logic      [63:0] cipher_low
);

    localparam int unsigned NR = aes_pkg::NUM_ROUNDS;

    logic [63:0]     key_high_reg;
    logic [63:0]     key_low_reg;
    logic [2:0]      reg_index;
    logic            advance;
    logic            s0_valid_reg;
    aes_pkg::block_t s0_state_reg;
    aes_pkg::block_t s0_key_reg;
    aes_pkg::stage_t stage [NR+1];

    assign pready    = 1'b1;
    assign reg_index = paddr[3:3] == 1'b1 ? aes_pkg::REG_KEY_LOW : aes_pkg::REG_KEY_HIGH;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (reg_index == aes_pkg::REG_KEY_HIGH)
            begin
                key_high_reg <= pwdata;
            end
            else
            begin
                key_low_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        case (reg_index)
            aes_pkg::REG_KEY_HIGH: prdata = key_high_reg;
            aes_pkg::REG_KEY_LOW:  prdata = key_low_reg;
            default:               prdata = '0;
        endcase
    end

    assign advance  = !stage[NR].valid || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_state_reg <= {plain_high, plain_low} ^ {key_high_reg, key_low_reg};
            s0_key_reg   <= {key_high_reg, key_low_reg};
        end
    end

    assign stage[0] = '{valid: s0_valid_reg, state: s0_state_reg,
                        round_key: s0_key_reg, rcon: aes_pkg::RCON_FIRST};

    for (genvar i = 0; i < NR; i++)
    begin : g_round
        aes_round_cell #(
            .LAST_ROUND(i == NR - 1)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .advance(advance),
            .prev   (stage[i]),
            .curr   (stage[i+1])
        );
    end

    assign out_valid   = stage[NR].valid;
    assign cipher_high = stage[NR].state[127:64];
    assign cipher_low  = stage[NR].state[63:0];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cipher_high) && $stable(cipher_low))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipeline stalled with empty output");
    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && s0_valid_reg |=> stage[1].valid)
        else $error("item lost between stages");

endmodule

`default_nettype wire
